// ===== sv/rsm_pkg.sv =====
// Shared types, codes and constants of the response string matcher.
`default_nettype none

package rsm_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int MAX_PATTERN_DEFAULT = 16;
    localparam int BUFFER_SIZE_DEFAULT = 300;

    // Widths fixed by the programming interface.
    localparam int PAT_REG_W   = 64;
    localparam int PAT_CHARS   = 16;
    localparam int PAT_W       = 2 * PAT_REG_W;
    localparam int PLEN_W      = 5;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    // Text that ends the wait when the fail watch is on.
    localparam int FAIL_LEN = 11;
    localparam logic [BYTE_W-1:0] FAIL_TEXT [0:FAIL_LEN-1] = '{
        "F", "A", "I", "L", "E", "D", " ", "C", "A", "L", "L"
    };

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_ERROR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_WAIT    = 3'd1,
        ST_MATCH   = 3'd2,
        ST_FAILED  = 3'd3,
        ST_TIMEOUT = 3'd4,
        ST_RDERR   = 3'd5,
        ST_FULL    = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW     = 3'd0,
        REG_PATTERN_HIGH    = 3'd1,
        REG_PATTERN_LENGTH  = 3'd2,
        REG_FAIL_WATCH      = 3'd3,
        REG_TIMEOUT_SECONDS = 3'd4
    } reg_idx_t;

    // Register contents as seen by the matching engine.
    typedef struct packed {
        logic [PAT_W-1:0]     pattern;
        logic [PLEN_W-1:0]    pattern_length;
        logic                 fail_watch;
        logic [TIMEOUT_W-1:0] timeout_seconds;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/rsm_cfg.sv =====
// Configuration register file of the response string matcher.
`default_nettype none

module rsm_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [rsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                  cfg_ready,
    output rsm_pkg::cfg_t                         cfg
);

    logic [rsm_pkg::PAT_REG_W-1:0] pattern_low_reg;
    logic [rsm_pkg::PAT_REG_W-1:0] pattern_high_reg;
    logic [rsm_pkg::PLEN_W-1:0]    pattern_length_reg;
    logic                          fail_watch_reg;
    logic [rsm_pkg::TIMEOUT_W-1:0] timeout_seconds_reg;

    // Writes are always taken; the register file never stalls them.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg     <= '0;
            pattern_high_reg    <= '0;
            pattern_length_reg  <= '0;
            fail_watch_reg      <= 1'b0;
            timeout_seconds_reg <= rsm_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rsm_pkg::REG_PATTERN_LOW:
                    pattern_low_reg <= cfg_data;
                rsm_pkg::REG_PATTERN_HIGH:
                    pattern_high_reg <= cfg_data;
                rsm_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[rsm_pkg::PLEN_W-1:0];
                rsm_pkg::REG_FAIL_WATCH:
                    fail_watch_reg <= cfg_data[0];
                rsm_pkg::REG_TIMEOUT_SECONDS:
                    timeout_seconds_reg <= cfg_data[rsm_pkg::TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.pattern         = {pattern_high_reg, pattern_low_reg};
        cfg.pattern_length  = pattern_length_reg;
        cfg.fail_watch      = fail_watch_reg;
        cfg.timeout_seconds = timeout_seconds_reg;
    end

endmodule

`default_nettype wire

// ===== sv/rsm_engine.sv =====
// Matching engine: character window, counters and the combinational outcome logic.
`default_nettype none

module rsm_engine #(
    parameter int MAX_PATTERN = rsm_pkg::MAX_PATTERN_DEFAULT,
    parameter int BUFFER_SIZE = rsm_pkg::BUFFER_SIZE_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic [1:0]                  command,
    input  wire logic [rsm_pkg::BYTE_W-1:0]  data_byte,
    input  rsm_pkg::cfg_t                    cfg,
    output rsm_pkg::status_t                 status
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int CNT_W = $clog2(BUFFER_SIZE);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int EXT_W = rsm_pkg::PLEN_W + 1;

    logic [rsm_pkg::CHAR_W-1:0]    window_reg  [MAX_PATTERN];
    logic [rsm_pkg::CHAR_W-1:0]    window_next [MAX_PATTERN];
    logic [rsm_pkg::CHAR_W-1:0]    window_shift [MAX_PATTERN];
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              count_inc;
    logic [rsm_pkg::TIMEOUT_W-1:0] seconds_reg;
    logic [rsm_pkg::TIMEOUT_W-1:0] seconds_next;
    logic [rsm_pkg::TIMEOUT_W-1:0] seconds_dec;
    logic                          armed_reg;
    logic                          armed_next;

    logic [rsm_pkg::BYTE_W-1:0]    pat_chars [MAX_PATTERN];
    logic [rsm_pkg::CHAR_W-1:0]    ch;
    logic [LEN_W-1:0]              eff_len;
    logic                          pat_hit;
    logic                          fail_hit;
    logic                          full_hit;

    rsm_pkg::cmd_t                 cmd;

    assign cmd = rsm_pkg::cmd_t'(command);
    assign ch  = data_byte[rsm_pkg::CHAR_W-1:0];

    // Pattern characters past the register pair read as zero and never match.
    for (genvar gi = 0; gi < MAX_PATTERN; gi++)
    begin : g_pat
        if (gi < rsm_pkg::PAT_CHARS)
        begin : g_used
            assign pat_chars[gi] = cfg.pattern[rsm_pkg::BYTE_W*gi +: rsm_pkg::BYTE_W];
        end
        else
        begin : g_zero
            assign pat_chars[gi] = '0;
        end
    end

    // The window after appending the new character; entry 0 is the newest.
    always_comb
    begin
        window_shift[0] = ch;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_shift[k] = window_reg[k-1];
        end
    end

    assign count_inc   = count_reg + 1'b1;
    assign seconds_dec = seconds_reg - 1'b1;

    always_comb
    begin
        if ({1'b0, cfg.pattern_length} > EXT_W'(MAX_PATTERN))
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = LEN_W'(cfg.pattern_length);
        end
    end

    // Pattern compare: pattern character i against the character len-1-i places back.
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        idx     = '0;
        pat_hit = (CMP_W'(count_inc) >= CMP_W'(eff_len));
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (LEN_W'(i) < eff_len)
            begin
                idx = eff_len - LEN_W'(i) - 1'b1;
                if (pat_chars[i] != {1'b0, window_shift[idx[IDX_W-1:0]]})
                begin
                    pat_hit = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        fail_hit = (CMP_W'(count_inc) >= CMP_W'(rsm_pkg::FAIL_LEN));
        for (int i = 0; i < rsm_pkg::FAIL_LEN; i++)
        begin
            if (rsm_pkg::FAIL_TEXT[i] != {1'b0, window_shift[rsm_pkg::FAIL_LEN-1-i]})
            begin
                fail_hit = 1'b0;
            end
        end
    end

    assign full_hit = (count_inc >= CNT_W'(BUFFER_SIZE - 1));

    always_comb
    begin
        window_next  = window_reg;
        count_next   = count_reg;
        seconds_next = seconds_reg;
        armed_next   = armed_reg;
        status       = rsm_pkg::ST_IDLE;

        if (cmd == rsm_pkg::CMD_START)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_next[k] = '0;
            end
            count_next   = '0;
            seconds_next = cfg.timeout_seconds;
            if (eff_len == '0)
            begin
                armed_next = 1'b0;
                status     = rsm_pkg::ST_MATCH;
            end
            else
            begin
                armed_next = 1'b1;
                status     = rsm_pkg::ST_WAIT;
            end
        end
        else if (armed_reg)
        begin
            case (cmd)
                rsm_pkg::CMD_BYTE:
                begin
                    status = rsm_pkg::ST_WAIT;
                    if (ch != '0)
                    begin
                        window_next = window_shift;
                        count_next  = count_inc;
                        if (pat_hit)
                        begin
                            status     = rsm_pkg::ST_MATCH;
                            armed_next = 1'b0;
                        end
                        else if (full_hit)
                        begin
                            status     = rsm_pkg::ST_FULL;
                            armed_next = 1'b0;
                        end
                        else if (cfg.fail_watch && fail_hit)
                        begin
                            status     = rsm_pkg::ST_FAILED;
                            armed_next = 1'b0;
                        end
                    end
                end
                rsm_pkg::CMD_TICK:
                begin
                    status = rsm_pkg::ST_WAIT;
                    if (seconds_reg != '0)
                    begin
                        seconds_next = seconds_dec;
                        if (seconds_dec == '0)
                        begin
                            armed_next = 1'b0;
                            status     = rsm_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                    armed_next = 1'b0;
                    status     = rsm_pkg::ST_RDERR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_reg[k] <= '0;
            end
            count_reg   <= '0;
            seconds_reg <= '0;
            armed_reg   <= 1'b0;
        end
        else if (en)
        begin
            window_reg  <= window_next;
            count_reg   <= count_next;
            seconds_reg <= seconds_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/response_string_matcher_unit.sv =====
// Top level of the response string matcher: handshakes, input register and result register.
`default_nettype none

// The matcher watches a stream of received bytes for a configured response pattern
// of up to MAX_PATTERN characters. A start command clears the stored text, loads the
// timeout and arms the matcher (an empty pattern answers matched at once). Each byte
// is stripped to 7 bits, zero bytes are ignored, and after every appended character
// the pattern is compared against the end of the text, then the buffer-full limit of
// BUFFER_SIZE-1 characters, then (with the fail watch on) the text FAILED CALL.
// Tick commands count the timeout down; a read error command ends the wait. Every
// command transaction yields exactly one status transaction. The unit accepts one
// transaction per clock cycle while the output is not stalled. A command is held in
// the input register until the result register can take its status, and the status
// then stays in the result register until it is taken. The rate is set by the
// parallel compare of the recent-character window, which updates the matcher state
// once per command. Configuration writes complete in the cycle they are presented and
// must be made while no command is in flight.
module response_string_matcher_unit #(
    parameter int MAX_PATTERN = rsm_pkg::MAX_PATTERN_DEFAULT,
    parameter int BUFFER_SIZE = rsm_pkg::BUFFER_SIZE_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      command,
    input  wire logic [rsm_pkg::BYTE_W-1:0]      data_byte,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [2:0]                           status,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rsm_pkg::cfg_t                 cfg;
    rsm_pkg::status_t              engine_status;

    // Input register stage.
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [1:0]                    s1_cmd_reg;
    logic [rsm_pkg::BYTE_W-1:0]    s1_byte_reg;

    // Result register stage.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [2:0]                    status_reg;

    logic                          advance;
    logic                          in_take;
    logic                          engine_en;

    // The result stage can take a new status when it is empty or being drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign engine_en = s1_valid_reg && advance;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    rsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    // The engine commits its state exactly when the held command moves to the result stage.
    rsm_engine #(
        .MAX_PATTERN (MAX_PATTERN),
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (engine_en),
        .command   (s1_cmd_reg),
        .data_byte (s1_byte_reg),
        .cfg       (cfg),
        .status    (engine_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= command;
            s1_byte_reg <= data_byte;
        end
        if (engine_en)
        begin
            status_reg <= engine_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== bench/rsm_checker.sv =====
// Checker for the response string matcher: predicts every status transaction and compares it.
module rsm_checker
    import rsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [1:0]            command,
    input  wire logic [BYTE_W-1:0]     data_byte,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [2:0]            status,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_results,
    output int                         live_items
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW  = MAX_PATTERN_DEFAULT;
    localparam int FULL_AT = BUFFER_SIZE_DEFAULT - 1;

    // Register copies.
    logic [PAT_REG_W-1:0] pat_lo;
    logic [PAT_REG_W-1:0] pat_hi;
    logic [PLEN_W-1:0]    pat_len;
    logic                 watch_fail;
    logic [TIMEOUT_W-1:0] timeout_load;

    // Matcher state.
    logic [CHAR_W-1:0]    window [0:WINDOW-1];
    int unsigned          char_count;
    logic [TIMEOUT_W-1:0] ticks_left;
    logic                 waiting;

    status_t              status_queue [$];

    function automatic logic [BYTE_W-1:0] pattern_byte(int i);
        if (i < 8)
            return pat_lo[8*i +: 8];
        if (i < 16)
            return pat_hi[8*(i-8) +: 8];
        return '0;
    endfunction

    function automatic bit tail_matches_pattern();
        int n;
        n = (pat_len > WINDOW) ? WINDOW : int'(pat_len);
        if (char_count < n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (pattern_byte(i) != {1'b0, window[n-1-i]})
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit tail_is_fail_text();
        if (char_count < FAIL_LEN)
            return 1'b0;
        for (int i = 0; i < FAIL_LEN; i++)
            if (FAIL_TEXT[i] != {1'b0, window[FAIL_LEN-1-i]})
                return 1'b0;
        return 1'b1;
    endfunction

    // Advances the matcher by one command and returns the status it answers.
    function automatic status_t step_matcher(cmd_t cmd, logic [BYTE_W-1:0] b);
        status_t           st;
        logic [CHAR_W-1:0] ch;
        ch = b[CHAR_W-1:0];
        st = ST_IDLE;
        if (cmd == CMD_START) begin
            foreach (window[k])
                window[k] = '0;
            char_count = 0;
            ticks_left = timeout_load;
            waiting    = (pat_len != 0);
            st         = waiting ? ST_WAIT : ST_MATCH;
        end else if (!waiting) begin
            st = ST_IDLE;
        end else if (cmd == CMD_BYTE) begin
            st = ST_WAIT;
            if (ch != 0) begin
                for (int k = WINDOW - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = ch;
                char_count++;
                if (tail_matches_pattern())
                    st = ST_MATCH;
                else if (char_count >= FULL_AT)
                    st = ST_FULL;
                else if (watch_fail && tail_is_fail_text())
                    st = ST_FAILED;
                if (st != ST_WAIT)
                    waiting = 1'b0;
            end
        end else if (cmd == CMD_TICK) begin
            st = ST_WAIT;
            if (ticks_left != 0) begin
                ticks_left--;
                if (ticks_left == 0) begin
                    waiting = 1'b0;
                    st      = ST_TIMEOUT;
                end
            end
        end else begin
            waiting = 1'b0;
            st      = ST_RDERR;
        end
        return st;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        status_t want;
        cmd_t    cmd;
        if (!rst_n) begin
            pat_lo          = '0;
            pat_hi          = '0;
            pat_len         = '0;
            watch_fail      = 1'b0;
            timeout_load    = TIMEOUT_RESET;
            foreach (window[k])
                window[k] = '0;
            char_count      = 0;
            ticks_left      = '0;
            waiting         = 1'b0;
            status_queue.delete();
            fail_count      = 0;
            pending_results = 0;
            live_items      = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (status_queue.size() == 0) begin
                    note_failure($sformatf("status %0d with no command outstanding", status));
                end else begin
                    want = status_queue.pop_front();
                    if (status !== want)
                        note_failure($sformatf("status: expected %0d (%s), got %0d",
                                               want, want.name(), status));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PATTERN_LOW:     pat_lo       = cfg_data;
                    REG_PATTERN_HIGH:    pat_hi       = cfg_data;
                    REG_PATTERN_LENGTH:  pat_len      = cfg_data[PLEN_W-1:0];
                    REG_FAIL_WATCH:      watch_fail   = cfg_data[0];
                    REG_TIMEOUT_SECONDS: timeout_load = cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                cmd = cmd_t'(command);
                if (cmd == CMD_START
                    || (waiting && !(cmd == CMD_BYTE && data_byte[CHAR_W-1:0] == 0)
                                && !(cmd == CMD_TICK && ticks_left == 0)))
                    live_items++;
                status_queue.push_back(step_matcher(cmd, data_byte));
            end
            pending_results = status_queue.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the response string matcher testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    // Number of non-ignored command transactions after which the random part stops.
    localparam int ITEM_TARGET = 2000;
    // Hard stop for the whole run, far beyond the slowest correct run.
    localparam int WATCHDOG_NS = 5_000_000;
    // Length of a run of bytes that must fill the buffer.
    localparam int FILL_BYTES  = BUFFER_SIZE_DEFAULT;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    wire logic             in_stall;
    logic [1:0]            command;
    logic [BYTE_W-1:0]     data_byte;
    wire logic             out_valid;
    logic                  out_stall = 1'b0;
    wire logic [2:0]       status;
    logic                  cfg_valid;
    wire logic             cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_results;
    int live_items;

    // What the stimulus knows about the current setting, so that it can build
    // sequences that actually reach a match, a fail text or a timeout.
    logic [BYTE_W-1:0]    pat_chars [0:PAT_CHARS-1];
    int                   pat_eff;
    logic [TIMEOUT_W-1:0] timeout_now;

    int          burst_left;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_run = 0;

    response_string_matcher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rsm_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .live_items      (live_items)
    );

    always #5 clk = ~clk;

    // The receiver switches between stall patterns of its own: free running, light
    // random stalls, heavy random stalls and a fixed periodic pattern. Stall changes
    // only at the falling edge.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
            stall_run  = $urandom_range(20, 200);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_run % 7) < 3);
        endcase
    end

    // Random byte, with the edge values of the field mixed in more often than chance.
    function automatic logic [BYTE_W-1:0] any_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'h80;
            2:       return 8'hFF;
            3:       return 8'h7F;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One configuration write transaction. The valid stays high when writes follow
    // each other; the caller lowers it after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    // Writes every register from pat_chars and the arguments. Bits above each
    // register's width carry random values, and now and then a write goes to an
    // index with no register behind it.
    task automatic load_setting(int len, bit watch, logic [TIMEOUT_W-1:0] seconds);
        logic [PAT_REG_W-1:0]  lo;
        logic [PAT_REG_W-1:0]  hi;
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = pat_chars[i];
            hi[8*i +: 8] = pat_chars[i+8];
        end
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        word = {$urandom, $urandom};
        word[PLEN_W-1:0] = len[PLEN_W-1:0];
        write_reg(REG_PATTERN_LENGTH, word);
        word = {$urandom, $urandom};
        word[0] = watch;
        write_reg(REG_FAIL_WATCH, word);
        word = {$urandom, $urandom};
        word[TIMEOUT_W-1:0] = seconds;
        write_reg(REG_TIMEOUT_SECONDS, word);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(int'(REG_TIMEOUT_SECONDS) + 1,
                                                (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
        @(negedge clk);
        cfg_valid <= 1'b0;
        pat_eff     = (len > PAT_CHARS) ? PAT_CHARS : len;
        timeout_now = seconds;
    endtask

    // Sends one command transaction. The sender works in bursts: at the start of
    // each burst it may drop valid for a random gap, and some bursts are long runs
    // with no gap at all. The task returns at the rising edge that accepted it.
    task automatic send_item(cmd_t cmd, logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(100, 300);
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 3);
            end
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Stops sending and waits until every outstanding status has come back.
    // Returns at a falling edge, where the checker's counters are stable.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // A start followed by one of several kinds of traffic. Most kinds are well
    // formed, so that the wait gets deep enough to end in each outcome; the rest
    // is noise and broken sequences.
    task automatic run_sequence();
        int                kind;
        int                n;
        int                spoil;
        int                stop_at;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        send_item(CMD_START, any_byte());
        if (kind < 45)
        begin
            // Noise, then the pattern itself. Zero bytes and ticks may fall inside
            // it, and once in a while one character is spoiled.
            n = $urandom_range(0, 10);
            repeat (n) send_item(CMD_BYTE, any_byte());
            spoil = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, PAT_CHARS - 1)) : -1;
            for (int i = 0; i < pat_eff; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_BYTE, $urandom_range(0, 1) ? 8'h80 : 8'h00);
                if ($urandom_range(0, 19) == 0)
                    send_item(CMD_TICK, any_byte());
                b = (i == spoil) ? any_byte() : pat_chars[i];
                if ($urandom_range(0, 1) == 1)
                    b[BYTE_W-1] = 1'b1;
                send_item(CMD_BYTE, b);
            end
            n = $urandom_range(0, 3);
            repeat (n) send_item(CMD_BYTE, any_byte());
        end
        else if (kind < 60)
        begin
            // The fail text, sometimes cut short.
            n = $urandom_range(0, 6);
            repeat (n) send_item(CMD_BYTE, any_byte());
            stop_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, FAIL_LEN - 1))
                                                  : FAIL_LEN;
            for (int i = 0; i < stop_at; i++)
            begin
                b = FAIL_TEXT[i];
                if ($urandom_range(0, 1) == 1)
                    b[BYTE_W-1] = 1'b1;
                send_item(CMD_BYTE, b);
            end
        end
        else if (kind < 72)
        begin
            // Ticks, enough to run out a short timeout, with bytes in between.
            n = (timeout_now != 0 && timeout_now <= 40)
                ? int'(timeout_now) + int'($urandom_range(0, 2)) : int'($urandom_range(1, 8));
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_BYTE, any_byte());
                send_item(CMD_TICK, any_byte());
            end
        end
        else if (kind < 80)
        begin
            n = $urandom_range(0, 5);
            repeat (n) send_item(CMD_BYTE, any_byte());
            send_item(CMD_ERROR, any_byte());
        end
        else
        begin
            n = $urandom_range(1, 15);
            repeat (n) send_item(cmd_t'($urandom_range(CMD_START, CMD_ERROR)), any_byte());
        end
    endtask

    // Builds the setting of one phase. The first few phases cover fixed corners;
    // later ones are random with the extremes still drawn now and then.
    task automatic program_phase(int p);
        int                   len;
        bit                   watch;
        logic [TIMEOUT_W-1:0] seconds;
        for (int i = 0; i < PAT_CHARS; i++)
        begin
            case (p)
                1:       pat_chars[i] = BYTE_W'($urandom_range(0, 255));
                4:       pat_chars[i] = 8'hFF;
                5:       pat_chars[i] = 8'h00;
                default: pat_chars[i] = ($urandom_range(0, 15) == 0)
                                        ? ($urandom_range(0, 1) ? 8'h00
                                                                : BYTE_W'($urandom_range(128, 255)))
                                        : BYTE_W'($urandom_range(8'h20, 8'h7E));
            endcase
        end
        case (p)
            0:
            begin
                len = PAT_CHARS; watch = 1'b1; seconds = 16'd3;
            end
            1:
            begin
                len = 31;        watch = 1'b0; seconds = 16'd0;
            end
            2:
            begin
                len = 1;         watch = 1'b1; seconds = 16'hFFFF;
            end
            3:
            begin
                len = 0;         watch = 1'b0; seconds = 16'd1;
            end
            4:
            begin
                len = 5;         watch = 1'b1; seconds = 16'd5;
            end
            5:
            begin
                len = 3;         watch = 1'b0; seconds = 16'd2;
            end
            default:
            begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = $urandom_range(PAT_CHARS + 1, 31);
                    default: len = $urandom_range(1, PAT_CHARS);
                endcase
                watch = $urandom_range(0, 1);
                case ($urandom_range(0, 3))
                    0:       seconds = '0;
                    1:       seconds = TIMEOUT_W'($urandom_range(1, 2));
                    2:       seconds = TIMEOUT_W'($urandom_range(1, 12));
                    default: seconds = TIMEOUT_W'($urandom_range(0, 65535));
                endcase
            end
        endcase
        load_setting(len, watch, seconds);
    endtask

    initial
    begin
        string             on_line;
        logic [BYTE_W-1:0] avoid;
        logic [BYTE_W-1:0] b;
        int                p;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_START;
        data_byte  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        pat_eff     = 0;
        timeout_now = TIMEOUT_RESET;
        foreach (pat_chars[i])
            pat_chars[i] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. With the reset setting the block is not armed, so a byte
        // and a read error answer idle, and a start meets the empty pattern and
        // answers matched at once.
        send_item(CMD_BYTE, 8'h41);
        send_item(CMD_ERROR, 8'h00);
        send_item(CMD_START, 8'hFF);
        drain();

        // Pattern ON LINE with the fail watch on and a one-second timeout.
        on_line = "ON LINE";
        for (int i = 0; i < on_line.len(); i++)
            pat_chars[i] = on_line[i];
        load_setting(on_line.len(), 1'b1, 16'd1);

        // All-ones byte is stored as DEL, 0x80 strips to zero and is dropped, a zero
        // byte inside the pattern is dropped, and bit 7 on a pattern byte is stripped.
        // The match can only come with the last character, never on a short text.
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h80);
        for (int i = 0; i < on_line.len(); i++)
        begin
            if (i == 1)
                send_item(CMD_BYTE, 8'h00);
            b = on_line[i];
            if (i == 1)
                b[BYTE_W-1] = 1'b1;
            send_item(CMD_BYTE, b);
        end
        // Timeout after one tick, then a read error.
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_START, 8'h00);
        send_item(CMD_ERROR, 8'h00);
        // A start while armed restarts the wait; then the fail text ends it.
        send_item(CMD_START, 8'h00);
        send_item(CMD_START, 8'h00);
        for (int i = 0; i < FAIL_LEN; i++)
            send_item(CMD_BYTE, FAIL_TEXT[i]);

        // Random part in phases. Each phase starts from an idle block with every
        // status back, which also gives the sender its full pauses.
        drain();
        p = 0;
        while (live_items < ITEM_TARGET)
        begin
            program_phase(p);
            // In some phases one run fills the buffer: none of its characters is
            // the last pattern character or the last letter of the fail text, so
            // neither can end the text before the buffer is full.
            if ((p == 1 || p == 2 || $urandom_range(0, 9) == 0) && pat_eff != 0)
            begin
                avoid = {1'b0, pat_chars[pat_eff-1][CHAR_W-1:0]};
                send_item(CMD_START, any_byte());
                repeat (FILL_BYTES)
                begin
                    do
                    begin
                        b = BYTE_W'($urandom_range(1, 127));
                    end
                    while (b == avoid || b == FAIL_TEXT[FAIL_LEN-1]);
                    if ($urandom_range(0, 1) == 1)
                        b[BYTE_W-1] = 1'b1;
                    send_item(CMD_BYTE, b);
                end
            end
            repeat (30)
            begin
                run_sequence();
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
            drain();
            p++;
        end

        // Everything is back; let the block show any stray status before the verdict.
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("response_string_matcher_unit: match");
        else
            $display("response_string_matcher_unit: mismatch");
        $finish;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("response_string_matcher_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rsm_pkg.sv
sv/rsm_cfg.sv
sv/rsm_engine.sv
sv/response_string_matcher_unit.sv
bench/rsm_checker.sv
bench/tb_top.sv
